@@ hdl/tls_pkg.sv @@
// Shared types and constants for the toroidal life stepper.
// Command codes, status codes, life rule counts and stream widths.
// No dependencies.
package tls_pkg;

	localparam int CMD_WIDTH     = 2;
	localparam int ROW_IDX_WIDTH = 6;
	localparam int CELL_WIDTH    = 64;
	localparam int IN_WIDTH      = 72;
	localparam int OUT_WIDTH     = 72;

	typedef logic [CMD_WIDTH-1:0] cmd_t;
	typedef logic [3:0]           nb_count_t;

	localparam cmd_t CMD_WRITE   = 2'd0;
	localparam cmd_t CMD_READ    = 2'd1;
	localparam cmd_t CMD_ADVANCE = 2'd2;

	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_BAD_ROW = 1'b1;

	localparam nb_count_t BIRTH_COUNT   = 4'd3;
	localparam nb_count_t SURVIVE_COUNT = 4'd2;

endpackage

@@ hdl/toroidal_life_stepper_core.sv @@
// Top level of the toroidal life stepper: command decode, sweep sequencer, result register.
// Uses tls_pkg, tls_grid_mem and tls_row_eval.
//
// Channel  Dir  Handshake           Item
// s_*      in   s_tvalid/s_tready   one command: write row, read row or advance
// m_*      out  m_tvalid/m_tready   one result per command: read cells and status
//
// An advance sweeps the rows with one memory read at a time, set by the single read
// port of the grid memory.
// Reset clears all cells at once through per-row valid bits, with no clearing pass.
// A new command is taken while an earlier result still waits in the output register.
module toroidal_life_stepper_core #(
	parameter int GRID_ROWS = 32,
	parameter int GRID_COLS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// cmd[1:0], row_index[7:2], row_cells[71:8]
	input  logic [tls_pkg::IN_WIDTH-1:0]  s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// read_cells[63:0], status[64], zero fill [71:65]
	output logic [tls_pkg::OUT_WIDTH-1:0] m_tdata
);

	localparam int AW = $clog2(GRID_ROWS);
	localparam int SW = $clog2(GRID_ROWS + 3);
	localparam int CW = tls_pkg::CELL_WIDTH;
	localparam int OW = tls_pkg::OUT_WIDTH;
	localparam logic [SW-1:0] FirstWriteStep = SW'(3);
	localparam logic [SW-1:0] LastStep = SW'(GRID_ROWS + 2);
	localparam logic [AW-1:0] LastRow = AW'(GRID_ROWS - 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_READ  = 2'd1;
	localparam logic [1:0] ST_SWEEP = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]                            state_q;
	logic [SW-1:0]                         step_q;
	logic [GRID_COLS-1:0]                  prior_q;
	logic [GRID_COLS-1:0]                  cur_q;
	logic [GRID_COLS-1:0]                  first_q;
	logic [GRID_COLS-1:0]                  res_cells_q;
	logic                                  res_status_q;
	logic [GRID_COLS-1:0]                  out_cells_q;
	logic                                  out_status_q;
	logic                                  m_tvalid_q;

	tls_pkg::cmd_t                         in_cmd;
	logic [tls_pkg::ROW_IDX_WIDTH-1:0]     in_row;
	logic [CW-1:0]                         in_cells;
	logic                                  accept;
	logic                                  row_ok;
	logic                                  mem_we;
	logic [AW-1:0]                         mem_waddr;
	logic [GRID_COLS-1:0]                  mem_wdata;
	logic [AW-1:0]                         mem_raddr;
	logic [GRID_COLS-1:0]                  mem_rdata;
	logic [SW-1:0]                         rd_step;
	logic [SW-1:0]                         wr_step;
	logic [GRID_COLS-1:0]                  below;
	logic [GRID_COLS-1:0]                  new_row;
	logic                                  sweep_write;
	logic [CW-1:0]                         out_cells_ext;

	assign in_cmd   = s_tdata[1:0];
	assign in_row   = s_tdata[7:2];
	assign in_cells = s_tdata[71:8];
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign row_ok   = ({1'b0, in_row} < 7'(GRID_ROWS));

	assign rd_step     = step_q - SW'(1);
	assign wr_step     = step_q - FirstWriteStep;
	assign sweep_write = (state_q == ST_SWEEP) && (step_q >= FirstWriteStep);
	assign below       = (step_q == LastStep) ? first_q : mem_rdata;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wr_step[AW-1:0];
		mem_wdata = new_row;
		mem_raddr = in_row[AW-1:0];
		if (state_q == ST_SWEEP) begin
			mem_raddr = (step_q == '0) ? LastRow : rd_step[AW-1:0];
			mem_we    = sweep_write;
		end else if (accept && in_cmd == tls_pkg::CMD_WRITE && row_ok) begin
			mem_we    = 1'b1;
			mem_waddr = in_row[AW-1:0];
			mem_wdata = in_cells[GRID_COLS-1:0];
		end
	end

	tls_grid_mem #(
		.ROWS(GRID_ROWS),
		.COLS(GRID_COLS)
	) u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	tls_row_eval #(
		.COLS(GRID_COLS)
	) u_eval (
		.above   (prior_q),
		.cur     (cur_q),
		.below   (below),
		.next_row(new_row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (accept) begin
						case (in_cmd)
							tls_pkg::CMD_READ: state_q <= row_ok ? ST_READ : ST_DONE;
							tls_pkg::CMD_ADVANCE: state_q <= ST_SWEEP;
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_READ: begin
					state_q <= ST_DONE;
				end
				ST_SWEEP: begin
					step_q <= step_q + SW'(1);
					if (step_q == LastStep) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_cells_q  <= '0;
			res_status_q <= (in_cmd == tls_pkg::CMD_WRITE || in_cmd == tls_pkg::CMD_READ)
				&& !row_ok ? tls_pkg::STATUS_BAD_ROW : tls_pkg::STATUS_OK;
		end
		if (state_q == ST_READ) begin
			res_cells_q <= mem_rdata;
		end
		if (state_q == ST_SWEEP) begin
			if (step_q == SW'(1)) begin
				prior_q <= mem_rdata;
			end else if (step_q == SW'(2)) begin
				cur_q   <= mem_rdata;
				first_q <= mem_rdata;
			end else if (sweep_write) begin
				prior_q <= cur_q;
				cur_q   <= mem_rdata;
			end
		end
		if (state_q == ST_DONE && (!m_tvalid_q || m_tready)) begin
			out_cells_q  <= res_cells_q;
			out_status_q <= res_status_q;
		end
	end

	assign out_cells_ext = CW'(out_cells_q);
	assign m_tvalid      = m_tvalid_q;
	assign m_tdata       = OW'({out_status_q, out_cells_ext});

endmodule

@@ hdl/tls_grid_mem.sv @@
// Row memory of the cell grid: one write port, one registered read port.
// Per-row valid bits make never-written rows read as dead after reset.
// Depends on nothing outside this file.
module tls_grid_mem #(
	parameter int ROWS = 32,
	parameter int COLS = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    we,
	input  logic [$clog2(ROWS)-1:0] waddr,
	input  logic [COLS-1:0]         wdata,
	input  logic [$clog2(ROWS)-1:0] raddr,
	output logic [COLS-1:0]         rdata
);

	logic [COLS-1:0] mem [ROWS];
	logic [ROWS-1:0] row_valid_q;
	logic [COLS-1:0] rd_word_q;
	logic            rd_valid_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_word_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_q  <= 1'b0;
		end else begin
			if (we) begin
				row_valid_q[waddr] <= 1'b1;
			end
			rd_valid_q <= row_valid_q[raddr];
		end
	end

	assign rdata = rd_valid_q ? rd_word_q : '0;

endmodule

@@ hdl/tls_row_eval.sv @@
// Next-generation logic for one grid row under the B3/S23 rule.
// Columns wrap around; depends on tls_pkg for the rule counts.
module tls_row_eval #(
	parameter int COLS = 64
) (
	input  logic [COLS-1:0] above,
	input  logic [COLS-1:0] cur,
	input  logic [COLS-1:0] below,
	output logic [COLS-1:0] next_row
);

	for (genvar j = 0; j < COLS; j++) begin : g_col
		localparam int JL = (j == 0) ? COLS - 1 : j - 1;
		localparam int JR = (j == COLS - 1) ? 0 : j + 1;
		tls_pkg::nb_count_t count;

		assign count = tls_pkg::nb_count_t'(above[JL]) + tls_pkg::nb_count_t'(above[j])
			+ tls_pkg::nb_count_t'(above[JR]) + tls_pkg::nb_count_t'(cur[JL])
			+ tls_pkg::nb_count_t'(cur[JR]) + tls_pkg::nb_count_t'(below[JL])
			+ tls_pkg::nb_count_t'(below[j]) + tls_pkg::nb_count_t'(below[JR]);
		assign next_row[j] = (count == tls_pkg::BIRTH_COUNT)
			|| (count == tls_pkg::SURVIVE_COUNT && cur[j]);
	end

endmodule

@@ hdl/tls_checker.sv @@
// Port-level checks for toroidal_life_stepper_core, attached by bind.
// Depends on tls_pkg for the stream widths.
module tls_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [tls_pkg::IN_WIDTH-1:0]  s_tdata,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [tls_pkg::OUT_WIDTH-1:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("Result item changed or dropped while stalled.");

	a_out_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[71:65] == '0)
		else $error("Fill bits of the result item are not zero.");

	a_bad_row_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[64] |-> m_tdata[63:0] == '0)
		else $error("A bad row status came with nonzero cells.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("A command was taken while the previous one was still in work.");

endmodule

bind toroidal_life_stepper_core tls_checker u_tls_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
